/* hw/rtl/wbps_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the wildcard byte pattern scanner.
// Used by the scan cells, the top level and the port checker.

package wbps_pkg;

    localparam int PAT_BYTES  = 16;   // pattern bytes held in the config registers
    localparam int LEN_W      = 5;    // width of the pattern length register
    localparam int ADDR_W     = 64;   // address and byte counter width
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE       = 3'd4;

    typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;
    typedef logic [PAT_BYTES-1:0]      care_mask_t;
    typedef logic [LEN_W-1:0]          pat_len_t;

    // per-cycle control broadcast to every window cell
    typedef struct packed {
        logic shift;   // a request was accepted: take the neighbor's byte
        logic clear;   // region ends: return the byte to zero
    } cell_ctrl_t;

endpackage

/* hw/rtl/wbps_cell.sv */
`timescale 1ns / 1ps
// One window cell: holds a byte of the recent-byte window, hands it to the
// next cell on every shift and checks the incoming byte against its pattern byte.

module wbps_cell #(
    parameter int POS = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wbps_pkg::cell_ctrl_t ctrl,
    input  wbps_pkg::pat_bytes_t pat_bytes,
    input  wbps_pkg::care_mask_t care_mask,
    input  wbps_pkg::pat_len_t   pat_len,
    input  logic [7:0]           byte_in,
    output logic [7:0]           byte_out,
    output logic                 cell_ok
);
    import wbps_pkg::*;

    localparam pat_len_t POS_L = LEN_W'(POS);

    logic [7:0]     byte_reg;
    logic [7:0]     byte_next;
    logic           in_use;
    pat_len_t       pat_idx;

    // window position POS lines up with pattern byte len-1-POS
    assign in_use  = POS_L < pat_len;
    assign pat_idx = pat_len - POS_L - LEN_W'(1);

    // compare the byte this cell takes in, i.e. the window after the shift
    assign cell_ok = !in_use || !care_mask[pat_idx[3:0]]
                     || (byte_in == pat_bytes[pat_idx[3:0]]);

    always_comb begin
        byte_next = byte_reg;
        if (ctrl.shift) begin
            byte_next = ctrl.clear ? 8'd0 : byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

/* hw/rtl/wildcard_byte_pattern_scan_core.sv */
`timescale 1ns / 1ps
// Top level of the wildcard byte pattern scanner: config registers, the row of
// window cells, region bookkeeping and the output register. Needs wbps_pkg, wbps_cell.
//
// Usage:
//   s_ channel carries the region one byte per request (s_tdata), s_tlast on the
//   final byte. m_ channel gives at most one result per region: m_tuser = found,
//   m_tdata = region base plus match offset (zero when not found).
//   Config registers are written through cfg_we/cfg_index/cfg_wdata; a write
//   takes effect for the next accepted byte.
//   Each byte moves one step down a row of window cells; every cell compares
//   its byte with its pattern byte and the results are ANDed in the same cycle.
//   A result is registered and shows on m_ in the cycle after the byte that caused it is accepted.
//   Throughput: one byte per cycle while s_tready is high; the cell compare and
//   the 64-bit address add are combinational, in front of the output register.
//   s_tready stays high while the output register is empty or being drained;
//   when the receiver stalls with a result held, s_tready drops until it is taken.
//   Reset (aresetn low, synchronous) clears the registers, the window, the
//   byte count and the result valid flag; the first byte after reset starts a region.

module wildcard_byte_pattern_scan_core #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // byte stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] data_byte
    input  logic                                 s_tlast,   // last_byte
    // results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [wbps_pkg::ADDR_W-1:0]          m_tdata,   // [63:0] match_address
    output logic [0:0]                           m_tuser    // [0] found
);
    import wbps_pkg::*;

    localparam int CELLS = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;

    // configuration registers
    logic [63:0]        pat_lo_reg;
    logic [63:0]        pat_hi_reg;
    care_mask_t         care_reg;
    pat_len_t           len_reg;
    logic [ADDR_W-1:0]  base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            care_reg   <= '0;
            len_reg    <= '0;
            base_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PATTERN_LO: pat_lo_reg <= cfg_wdata;
                REG_PATTERN_HI: pat_hi_reg <= cfg_wdata;
                REG_CARE_MASK:  care_reg   <= cfg_wdata[PAT_BYTES-1:0];
                REG_LENGTH:     len_reg    <= cfg_wdata[LEN_W-1:0];
                REG_BASE:       base_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    pat_bytes_t pat_bytes;
    assign pat_bytes = {pat_hi_reg, pat_lo_reg};

    // handshake
    logic out_valid_reg;
    logic accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // window cells
    cell_ctrl_t  cell_ctrl;
    logic [7:0]  cell_byte [CELLS+1];
    logic [CELLS-1:0] cell_ok;

    assign cell_ctrl.shift = accept;
    assign cell_ctrl.clear = s_tlast;
    assign cell_byte[0]    = s_tdata;

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        wbps_cell #(
            .POS(i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .pat_bytes (pat_bytes),
            .care_mask (care_reg),
            .pat_len   (len_reg),
            .byte_in   (cell_byte[i]),
            .byte_out  (cell_byte[i+1]),
            .cell_ok   (cell_ok[i])
        );
    end

    // region bookkeeping
    logic [ADDR_W-1:0]  seen_reg;
    logic [ADDR_W-1:0]  seen_next;
    logic               done_reg;
    logic               done_next;
    logic [ADDR_W-1:0]  seen_inc;
    logic               len_ok;
    logic               fill_ok;
    logic               hit;
    logic [ADDR_W-1:0]  hit_addr;

    assign seen_inc = seen_reg + ADDR_W'(1);
    assign len_ok   = (len_reg != '0) && (len_reg <= LEN_W'(CELLS));
    assign fill_ok  = (|seen_inc[ADDR_W-1:LEN_W]) || (seen_inc[LEN_W-1:0] >= len_reg);
    assign hit      = !done_reg && len_ok && (base_reg != '0) && fill_ok && (&cell_ok);
    assign hit_addr = base_reg + seen_inc - {{(ADDR_W-LEN_W){1'b0}}, len_reg};

    always_comb begin
        seen_next = seen_reg;
        done_next = done_reg;
        if (accept) begin
            if (s_tlast) begin
                seen_next = '0;
                done_next = 1'b0;
            end else begin
                seen_next = seen_inc;
                done_next = done_reg || hit;
            end
        end
    end

    // output register
    logic               out_valid_next;
    logic               found_reg;
    logic               found_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;

    always_comb begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        addr_next      = addr_reg;
        if (accept) begin
            // a match wins over the end-of-region report
            out_valid_next = hit || (s_tlast && !done_reg);
            found_next     = hit;
            addr_next      = hit ? hit_addr : '0;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            seen_reg      <= seen_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
        addr_reg  <= addr_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = addr_reg;
    assign m_tuser  = found_reg;

endmodule

/* hw/rtl/wbps_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the wildcard byte pattern scanner, bound to the top level.
// Sees only the top-level ports; needs wbps_pkg.

module wbps_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [wbps_pkg::ADDR_W-1:0]     m_tdata,
    input  logic [0:0]                      m_tuser
);
    import wbps_pkg::*;

    // hold a stalled result
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a not-found result carries a zero address
    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("not-found result with nonzero address");

    // a fresh not-found result follows the last byte of a region
    a_notfound_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] && !$past(m_tvalid && !m_tready)
        |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("not-found result without a last byte");

    // an empty output register never stalls the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind wildcard_byte_pattern_scan_core wbps_checker u_wbps_checker (.*);

/* dv/wildcard_byte_pattern_scan_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_byte_pattern_scan_core: directed cases, then random
// regions under four flow-control phases. Needs wbps_pkg and the scanner RTL.

module wildcard_byte_pattern_scan_core_tb;
    import wbps_pkg::*;

    localparam int SCAN_MAX      = 16;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 5000;
    localparam int PRINT_LIMIT   = 40;
    localparam int REGION_MAX    = 48;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = 3'd7;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] address;
    } scan_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [ADDR_W-1:0]     m_tdata;
    logic [0:0]            m_tuser;

    // scanner configuration as the block should hold it
    logic [63:0]       pat_lo = '0;
    logic [63:0]       pat_hi = '0;
    care_mask_t        care_mask = '0;
    pat_len_t          pat_len = '0;
    logic [ADDR_W-1:0] region_base = '0;

    // region state
    logic [7:0]        scan_window [SCAN_MAX] = '{default: 8'h00};
    logic [ADDR_W-1:0] region_bytes_seen = '0;
    logic              region_matched = 1'b0;

    scan_result_t expected_results[$];
    scan_result_t oldest_result;
    int unsigned  bytes_sent = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;

    always #5 aclk = ~aclk;

    wildcard_byte_pattern_scan_core #(
        .MAX_PATTERN(SCAN_MAX)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // Append one result at the tail of the expected queue.
    task automatic enqueue_expected(input scan_result_t res);
        expected_results.insert(expected_results.size(), res);
    endtask

    // Advance the region state by one accepted byte and queue any result it causes.
    task automatic predict_scan(input logic [7:0] value, input logic is_last);
        scan_result_t res;
        logic [127:0] pattern;
        logic         hit;
        pattern = {pat_hi, pat_lo};
        for (int i = SCAN_MAX - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
        scan_window[0] = value;
        region_bytes_seen++;
        hit = !region_matched && pat_len != 0 && pat_len <= SCAN_MAX &&
              region_base != 0 && region_bytes_seen >= pat_len;
        if (hit) begin
            // pattern byte 0 lines up with the oldest byte of the window slice
            for (int k = 0; k < SCAN_MAX; k++) begin
                if (k < pat_len && care_mask[k] &&
                    scan_window[pat_len - 1 - k] != pattern[8*k +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
        if (hit) begin
            res.found   = 1'b1;
            res.address = region_base + (region_bytes_seen - pat_len);
            enqueue_expected(res);
            region_matched = 1'b1;
        end
        if (is_last) begin
            if (!region_matched) begin
                res.found   = 1'b0;
                res.address = '0;
                enqueue_expected(res);
            end
            scan_window       = '{default: 8'h00};
            region_bytes_seen = '0;
            region_matched    = 1'b0;
        end
    endtask

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        predict_scan(value, is_last);
    endtask

    // Hold the sender until every queued result has come, then let the pipeline settle.
    task automatic await_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        case (index)
            REG_PATTERN_LO: pat_lo      = value;
            REG_PATTERN_HI: pat_hi      = value;
            REG_CARE_MASK:  care_mask   = value[PAT_BYTES-1:0];
            REG_LENGTH:     pat_len     = value[LEN_W-1:0];
            REG_BASE:       region_base = value;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [63:0] mask, input logic [63:0] len,
                               input logic [63:0] base);
        await_idle();
        write_reg(REG_PATTERN_LO, lo);
        write_reg(REG_PATTERN_HI, hi);
        write_reg(REG_CARE_MASK, mask);
        write_reg(REG_LENGTH, len);
        write_reg(REG_BASE, base);
        // a write past the register list must leave everything alone
        write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LAST, REG_UNMAPPED_FIRST)),
                  {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_values();
        // length is zero after reset: the region ends without a match
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_wrap_and_after_match();
        // one-byte pattern, base at the top of the address space: match at offset 1 wraps to 0
        load_config(64'h0000_0000_0000_00FF, {$urandom, $urandom}, 64'h5A5A_0000_0000_0001,
                    64'hFFFF_FFFF_FFFF_FFE1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b1);
    endtask

    task automatic test_wildcard_and_last_byte();
        // pattern AA BB ?? DD, match completes on the last byte
        load_config(64'h0123_4567_DD77_BBAA, 64'h0, 64'hABCD_0000_0000_000B,
                    64'hFFFF_FFFF_FFFF_FFE4, 64'h0000_0000_0000_0100);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hDD, 1'b1);
        // region shorter than the pattern
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b1);
    endtask

    task automatic test_never_match();
        // all-wildcard byte would match, but base zero disables the search
        load_config(64'h0, 64'h0, 64'h0, 64'h1, 64'h0);
        send_byte(8'h7F, 1'b1);
        // length beyond the window
        load_config(64'h0, 64'h0, 64'h0, 64'h1F, 64'h5);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_random_scan(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned item_count);
        int unsigned  start_count;
        int unsigned  region_len;
        int unsigned  at;
        int unsigned  pick;
        logic [63:0]  mask_word;
        logic [63:0]  len_word;
        logic [63:0]  base_word;
        logic [127:0] pattern;
        logic [7:0]   region [REGION_MAX];
        bit           first_region;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_count    = bytes_sent;
        first_region   = 1'b1;
        while (bytes_sent - start_count < item_count) begin
            if (first_region || $urandom_range(2) == 0) begin
                mask_word = {$urandom, $urandom};
                pick = $urandom_range(99);
                if (pick < 15) mask_word[15:0] = 16'hFFFF;
                else if (pick < 25) mask_word[15:0] = 16'h0000;
                len_word = {$urandom, $urandom};
                pick = $urandom_range(99);
                if (pick < 8) len_word[4:0] = 5'd0;
                else if (pick < 18) len_word[4:0] = 5'($urandom_range(31, 17));
                else if (pick < 35) len_word[4:0] = 5'd16;
                else if (pick < 45) len_word[4:0] = 5'd1;
                else len_word[4:0] = 5'($urandom_range(15, 2));
                pick = $urandom_range(99);
                if (pick < 5) base_word = '0;
                else if (pick < 12) base_word = '1;
                else if (pick < 18) base_word = 64'hFFFF_FFFF_FFFF_FFF0;
                else base_word = {$urandom, $urandom};
                load_config({$urandom, $urandom}, {$urandom, $urandom}, mask_word,
                            len_word, base_word);
                first_region = 1'b0;
            end
            pattern    = {pat_hi, pat_lo};
            region_len = ($urandom_range(4) == 0) ? $urandom_range(REGION_MAX, 21)
                                                  : $urandom_range(20, 1);
            // noise biased toward pattern bytes gives many near misses
            for (int i = 0; i < region_len; i++) begin
                if ($urandom_range(1) == 0) region[i] = pattern[8*$urandom_range(15) +: 8];
                else region[i] = 8'($urandom);
            end
            if ($urandom_range(3) != 0 && pat_len != 0 && pat_len <= SCAN_MAX &&
                pat_len <= region_len) begin
                at = $urandom_range(region_len - pat_len);
                for (int k = 0; k < pat_len; k++) begin
                    if (care_mask[k]) region[at + k] = pattern[8*k +: 8];
                end
            end
            for (int i = 0; i < region_len; i++) begin
                send_byte(region[i], i == region_len - 1);
            end
            if ($urandom_range(9) == 0) await_idle();
        end
    endtask

    // receiver side
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with none expected", m_tdata, 64'h0);
            end else begin
                oldest_result = expected_results.pop_front();
                if (m_tuser[0] !== oldest_result.found) begin
                    report_mismatch("found", 64'(m_tuser), 64'(oldest_result.found));
                end
                if (m_tdata !== oldest_result.address) begin
                    report_mismatch("match_address", m_tdata, oldest_result.address);
                end
            end
        end
    end

    // watchdog: count cycles in which no request, result or register write moves
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_PATTERN_LO;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_wrap_and_after_match();
        test_wildcard_and_last_byte();
        test_never_match();
        test_random_scan(0, 0, 300);
        test_random_scan(87, 0, 300);
        test_random_scan(0, 87, 300);
        test_random_scan(18, 18, 300);

        await_idle();
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_cell.sv
hw/rtl/wildcard_byte_pattern_scan_core.sv
hw/rtl/wbps_checker.sv
dv/wildcard_byte_pattern_scan_core_tb.sv
